[rtl/i2cms_pkg.sv]
`default_nettype none

package i2cms_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_SLA_W  = 4'd2,
        PH_ADDR_H = 4'd3,
        PH_ADDR_L = 4'd4,
        PH_NEED   = 4'd5,
        PH_DATA   = 4'd6,
        PH_RSTART = 4'd7,
        PH_SLA_R  = 4'd8,
        PH_READ   = 4'd9
    } t_phase;

    localparam logic [2:0] MODE_BEGIN_WR = 3'd0;
    localparam logic [2:0] MODE_BEGIN_RD = 3'd1;
    localparam logic [2:0] MODE_WR_BYTE  = 3'd2;
    localparam logic [2:0] MODE_DONE     = 3'd3;
    localparam logic [2:0] MODE_TICK     = 3'd4;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RACK  = 3'd3;
    localparam logic [2:0] CMD_RNACK = 3'd4;
    localparam logic [2:0] CMD_STOP  = 3'd5;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_START     = 3'd1;
    localparam logic [2:0] ERR_ADDR_NACK = 3'd2;
    localparam logic [2:0] ERR_DATA_NACK = 3'd3;
    localparam logic [2:0] ERR_READ      = 3'd4;
    localparam logic [2:0] ERR_TIMEOUT   = 3'd5;

    localparam logic [7:0] ST_MASK           = 8'hF8;
    localparam logic [7:0] STAT_START        = 8'h08;
    localparam logic [7:0] STAT_RESTART      = 8'h10;
    localparam logic [7:0] STAT_WR_ADDR_ACK  = 8'h18;
    localparam logic [7:0] STAT_WR_DATA_ACK  = 8'h28;
    localparam logic [7:0] STAT_RD_ADDR_ACK  = 8'h40;
    localparam logic [7:0] STAT_RD_DATA_ACK  = 8'h50;
    localparam logic [7:0] STAT_RD_DATA_NACK = 8'h58;

    localparam logic [7:0] RW_READ_BIT     = 8'h01;
    localparam logic [7:0] TIMEOUT_RESET   = 8'd50;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] command_byte;
        logic       want_data;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       finished;
        logic [2:0] error_code;
    } t_result;

endpackage

`default_nettype wire

[rtl/i2c_master_transaction_sequencer.sv]
`default_nettype none
// i2c master register transaction sequencer
// input channel (i_valid / o_ready) carries one event per transaction: a begin
// write or begin read request, a write data byte, an engine completion with its
// status and received byte, or a timer tick. every event gives exactly one
// result on the output channel (o_valid / i_ready): the next engine command
// with its byte, a data request, a received byte, the finished flag or an
// error code (all zero when the event is ignored).
// o_valid rises in the cycle after input acceptance; one event is taken
// per cycle, set by the single result register after the phase update logic.
// while a result waits on a stalled receiver the block still takes the next
// event if the result is taken in the same cycle; otherwise o_ready drops
// until the result register is freed.
// the timeout register is written through i_cfg_valid / o_cfg_ready / i_cfg_data
// and is always ready; write it only while no transaction is in flight.
// synchronous active-low reset returns the sequencer to idle, clears the
// output register valid and sets the timeout to 50 ticks.
module i2c_master_transaction_sequencer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_dev_address,
    input  wire logic [15:0] i_reg_address,
    input  wire logic [1:0] i_address_length,
    input  wire logic [7:0] i_byte_count,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic [7:0] i_bus_status,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_bus_command,
    output logic [7:0]      o_command_byte,
    output logic            o_want_data,
    output logic            o_read_valid,
    output logic [7:0]      o_read_byte,
    output logic            o_finished,
    output logic [2:0]      o_error_code,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);
    import i2cms_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_is_read, n_is_read;
    logic [7:0]  r_device, n_device;
    logic [15:0] r_address, n_address;
    logic [1:0]  r_addr_len, n_addr_len;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_wait_count, n_wait_count;
    logic [7:0]  r_timeout_ticks;
    logic        r_out_valid;
    t_result     r_result, n_result;

    logic        w_accept;
    logic        w_busy;
    logic [7:0]  w_status;
    logic        w_status_ok;
    logic [2:0]  w_fail_code;
    logic [7:0]  w_left_dec;

    assign o_ready     = !r_out_valid || i_ready;
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign w_busy      = (r_phase != PH_IDLE) && (r_phase != PH_NEED);
    assign w_status    = i_bus_status & ST_MASK;
    assign w_left_dec  = r_bytes_left - 8'd1;

    // status check and error code for the phase awaiting completion
    always_comb begin
        w_status_ok = 1'b0;
        w_fail_code = ERR_NONE;
        unique case (r_phase)
            PH_START, PH_RSTART: begin
                w_status_ok = (w_status == STAT_START) || (w_status == STAT_RESTART);
                w_fail_code = ERR_START;
            end
            PH_SLA_W: begin
                w_status_ok = (w_status == STAT_WR_ADDR_ACK);
                w_fail_code = ERR_ADDR_NACK;
            end
            PH_SLA_R: begin
                w_status_ok = (w_status == STAT_RD_ADDR_ACK);
                w_fail_code = ERR_ADDR_NACK;
            end
            PH_ADDR_H, PH_ADDR_L, PH_DATA: begin
                w_status_ok = (w_status == STAT_WR_DATA_ACK);
                w_fail_code = ERR_DATA_NACK;
            end
            PH_READ: begin
                w_status_ok = (w_status == STAT_RD_DATA_ACK) ||
                              (w_status == STAT_RD_DATA_NACK);
                w_fail_code = ERR_READ;
            end
            default: begin
                w_status_ok = 1'b0;
                w_fail_code = ERR_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_is_read    = r_is_read;
        n_device     = r_device;
        n_address    = r_address;
        n_addr_len   = r_addr_len;
        n_bytes_left = r_bytes_left;
        n_wait_count = r_wait_count;
        if (w_accept) begin
            case (i_mode)
                MODE_BEGIN_WR, MODE_BEGIN_RD: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read    = (i_mode == MODE_BEGIN_RD);
                        n_device     = i_dev_address;
                        n_address    = i_reg_address;
                        n_addr_len   = i_address_length;
                        n_bytes_left = i_byte_count;
                        n_phase      = PH_START;
                        n_wait_count = r_timeout_ticks;
                    end
                end
                MODE_WR_BYTE: begin
                    if (r_phase == PH_NEED) begin
                        n_phase      = PH_DATA;
                        n_wait_count = r_timeout_ticks;
                    end
                end
                MODE_DONE: begin
                    if (w_busy) begin
                        if (!w_status_ok) begin
                            n_phase = PH_IDLE;
                        end else begin
                            unique case (r_phase)
                                PH_START: begin
                                    n_phase      = PH_SLA_W;
                                    n_wait_count = r_timeout_ticks;
                                end
                                PH_RSTART: begin
                                    n_phase      = PH_SLA_R;
                                    n_wait_count = r_timeout_ticks;
                                end
                                PH_SLA_W, PH_ADDR_H, PH_ADDR_L: begin
                                    if (r_phase == PH_SLA_W && r_addr_len == 2'd2) begin
                                        n_phase      = PH_ADDR_H;
                                        n_wait_count = r_timeout_ticks;
                                    end else if ((r_phase == PH_SLA_W && r_addr_len != 2'd0)
                                                 || r_phase == PH_ADDR_H) begin
                                        n_phase      = PH_ADDR_L;
                                        n_wait_count = r_timeout_ticks;
                                    end else if (r_is_read) begin
                                        n_phase      = PH_RSTART;
                                        n_wait_count = r_timeout_ticks;
                                    end else if (r_bytes_left == 8'd0) begin
                                        n_phase      = PH_IDLE;
                                        n_bytes_left = 8'd0;
                                    end else begin
                                        n_phase = PH_NEED;
                                    end
                                end
                                PH_DATA: begin
                                    n_bytes_left = w_left_dec;
                                    n_phase      = (w_left_dec == 8'd0) ? PH_IDLE : PH_NEED;
                                end
                                PH_SLA_R: begin
                                    n_phase      = PH_READ;
                                    n_wait_count = r_timeout_ticks;
                                end
                                PH_READ: begin
                                    if (r_bytes_left > 8'd1) begin
                                        n_bytes_left = w_left_dec;
                                        n_wait_count = r_timeout_ticks;
                                    end else begin
                                        n_phase      = PH_IDLE;
                                        n_bytes_left = 8'd0;
                                    end
                                end
                                default: begin
                                    n_phase = r_phase;
                                end
                            endcase
                        end
                    end
                end
                MODE_TICK: begin
                    if (w_busy) begin
                        if (r_wait_count <= 8'd1) begin
                            n_wait_count = 8'd0;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_wait_count = r_wait_count - 8'd1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result of the accepted transaction
    always_comb begin
        n_result = '0;
        case (i_mode)
            MODE_BEGIN_WR, MODE_BEGIN_RD: begin
                if (r_phase == PH_IDLE) begin
                    n_result.bus_command = CMD_START;
                end
            end
            MODE_WR_BYTE: begin
                if (r_phase == PH_NEED) begin
                    n_result.bus_command  = CMD_SEND;
                    n_result.command_byte = i_tx_byte;
                end
            end
            MODE_DONE: begin
                if (w_busy) begin
                    if (!w_status_ok) begin
                        n_result.error_code = w_fail_code;
                    end else begin
                        unique case (r_phase)
                            PH_START: begin
                                n_result.bus_command  = CMD_SEND;
                                n_result.command_byte = r_device & ~RW_READ_BIT;
                            end
                            PH_RSTART: begin
                                n_result.bus_command  = CMD_SEND;
                                n_result.command_byte = r_device | RW_READ_BIT;
                            end
                            PH_SLA_W, PH_ADDR_H, PH_ADDR_L: begin
                                if (r_phase == PH_SLA_W && r_addr_len == 2'd2) begin
                                    n_result.bus_command  = CMD_SEND;
                                    n_result.command_byte = r_address[15:8];
                                end else if ((r_phase == PH_SLA_W && r_addr_len != 2'd0)
                                             || r_phase == PH_ADDR_H) begin
                                    n_result.bus_command  = CMD_SEND;
                                    n_result.command_byte = r_address[7:0];
                                end else if (r_is_read) begin
                                    n_result.bus_command = CMD_START;
                                end else if (r_bytes_left == 8'd0) begin
                                    n_result.bus_command = CMD_STOP;
                                    n_result.finished    = 1'b1;
                                end else begin
                                    n_result.want_data = 1'b1;
                                end
                            end
                            PH_DATA: begin
                                if (w_left_dec == 8'd0) begin
                                    n_result.bus_command = CMD_STOP;
                                    n_result.finished    = 1'b1;
                                end else begin
                                    n_result.want_data = 1'b1;
                                end
                            end
                            PH_SLA_R: begin
                                n_result.bus_command =
                                    (r_bytes_left > 8'd1) ? CMD_RACK : CMD_RNACK;
                            end
                            PH_READ: begin
                                n_result.read_valid = 1'b1;
                                n_result.read_byte  = i_rx_byte;
                                if (r_bytes_left > 8'd1) begin
                                    n_result.bus_command =
                                        (w_left_dec > 8'd1) ? CMD_RACK : CMD_RNACK;
                                end else begin
                                    n_result.bus_command = CMD_STOP;
                                    n_result.finished    = 1'b1;
                                end
                            end
                            default: begin
                                n_result.bus_command = CMD_NONE;
                            end
                        endcase
                    end
                end
            end
            MODE_TICK: begin
                if (w_busy && r_wait_count <= 8'd1) begin
                    n_result.error_code = ERR_TIMEOUT;
                end
            end
            default: begin
                n_result.bus_command = CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_is_read       <= 1'b0;
            r_device        <= 8'd0;
            r_address       <= 16'd0;
            r_addr_len      <= 2'd0;
            r_bytes_left    <= 8'd0;
            r_wait_count    <= 8'd0;
            r_timeout_ticks <= TIMEOUT_RESET;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_is_read    <= n_is_read;
            r_device     <= n_device;
            r_address    <= n_address;
            r_addr_len   <= n_addr_len;
            r_bytes_left <= n_bytes_left;
            r_wait_count <= n_wait_count;
            if (i_cfg_valid) begin
                r_timeout_ticks <= i_cfg_data;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_bus_command  = r_result.bus_command;
    assign o_command_byte = r_result.command_byte;
    assign o_want_data    = r_result.want_data;
    assign o_read_valid   = r_result.read_valid;
    assign o_read_byte    = r_result.read_byte;
    assign o_finished     = r_result.finished;
    assign o_error_code   = r_result.error_code;

endmodule

`default_nettype wire

[test/i2c_master_transaction_sequencer_test.sv]
module i2c_master_transaction_sequencer_test;
    import i2cms_pkg::*;

    localparam int          NUM_SETS        = 6;
    localparam int          ITEMS_PER_SET   = 125;
    localparam int          HOLD_CYCLES     = 64;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  dev_address;
        logic [15:0] reg_address;
        logic [1:0]  address_length;
        logic [7:0]  byte_count;
        logic [7:0]  tx_byte;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
    } t_request;

    typedef enum {WANT_START, WANT_SLA_W, WANT_MT_DATA, WANT_SLA_R, WANT_MR_DATA} t_step;
    typedef enum {AT_IDLE, AT_NEED, AT_BUSY} t_spot;

    class sequencer_scoreboard;
        t_result    expected_results[$];
        int         errors;
        logic [7:0] timeout_ticks;
        t_phase     phase;
        logic       is_read;
        logic [7:0] device;
        logic [15:0] reg_address;
        logic [1:0] address_bytes;
        logic [7:0] bytes_left;
        logic [7:0] ticks_left;
        t_result    res;

        function new();
            errors = 0;
            timeout_ticks = TIMEOUT_RESET;
            phase = PH_IDLE;
            is_read = 1'b0;
            device = '0;
            reg_address = '0;
            address_bytes = '0;
            bytes_left = '0;
            ticks_left = '0;
        endfunction

        function void issue(logic [2:0] cmd, logic [7:0] value, t_phase nxt_phase);
            res.bus_command = cmd;
            res.command_byte = value;
            phase = nxt_phase;
            ticks_left = timeout_ticks;
        endfunction

        function void fail(logic [2:0] code);
            res.error_code = code;
            phase = PH_IDLE;
        endfunction

        function void finish_transfer();
            res.bus_command = CMD_STOP;
            res.finished = 1'b1;
            phase = PH_IDLE;
            bytes_left = '0;
        endfunction

        function void request_data();
            res.want_data = 1'b1;
            phase = PH_NEED;
        endfunction

        function void after_address();
            if (is_read)
                issue(CMD_START, 8'h00, PH_RSTART);
            else if (bytes_left == 0)
                finish_transfer();
            else
                request_data();
        endfunction

        function void note_event(t_request it);
            logic [7:0] st;
            st = it.bus_status & ST_MASK;
            res = '0;
            case (it.mode)
                MODE_BEGIN_WR, MODE_BEGIN_RD: begin
                    if (phase == PH_IDLE) begin
                        is_read = (it.mode == MODE_BEGIN_RD);
                        device = it.dev_address;
                        reg_address = it.reg_address;
                        address_bytes = it.address_length;
                        bytes_left = it.byte_count;
                        issue(CMD_START, 8'h00, PH_START);
                    end
                end
                MODE_WR_BYTE: begin
                    if (phase == PH_NEED)
                        issue(CMD_SEND, it.tx_byte, PH_DATA);
                end
                MODE_DONE: begin
                    case (phase)
                        PH_START, PH_RSTART: begin
                            if (st != STAT_START && st != STAT_RESTART)
                                fail(ERR_START);
                            else if (phase == PH_START)
                                issue(CMD_SEND, device & ~RW_READ_BIT, PH_SLA_W);
                            else
                                issue(CMD_SEND, device | RW_READ_BIT, PH_SLA_R);
                        end
                        PH_SLA_W: begin
                            if (st != STAT_WR_ADDR_ACK)
                                fail(ERR_ADDR_NACK);
                            else if (address_bytes == 2'd2)
                                issue(CMD_SEND, reg_address[15:8], PH_ADDR_H);
                            else if (address_bytes != 2'd0)
                                issue(CMD_SEND, reg_address[7:0], PH_ADDR_L);
                            else
                                after_address();
                        end
                        PH_ADDR_H: begin
                            if (st != STAT_WR_DATA_ACK)
                                fail(ERR_DATA_NACK);
                            else
                                issue(CMD_SEND, reg_address[7:0], PH_ADDR_L);
                        end
                        PH_ADDR_L: begin
                            if (st != STAT_WR_DATA_ACK)
                                fail(ERR_DATA_NACK);
                            else
                                after_address();
                        end
                        PH_DATA: begin
                            if (st != STAT_WR_DATA_ACK) begin
                                fail(ERR_DATA_NACK);
                            end else begin
                                bytes_left = bytes_left - 8'd1;
                                if (bytes_left == 0)
                                    finish_transfer();
                                else
                                    request_data();
                            end
                        end
                        PH_SLA_R: begin
                            if (st != STAT_RD_ADDR_ACK)
                                fail(ERR_ADDR_NACK);
                            else
                                issue((bytes_left > 1) ? CMD_RACK : CMD_RNACK, 8'h00, PH_READ);
                        end
                        PH_READ: begin
                            if (st != STAT_RD_DATA_ACK && st != STAT_RD_DATA_NACK) begin
                                fail(ERR_READ);
                            end else begin
                                res.read_valid = 1'b1;
                                res.read_byte = it.rx_byte;
                                if (bytes_left > 1) begin
                                    bytes_left = bytes_left - 8'd1;
                                    issue((bytes_left > 1) ? CMD_RACK : CMD_RNACK, 8'h00,
                                          PH_READ);
                                end else begin
                                    finish_transfer();
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_TICK: begin
                    if (phase != PH_IDLE && phase != PH_NEED) begin
                        if (ticks_left <= 1) begin
                            ticks_left = '0;
                            fail(ERR_TIMEOUT);
                        end else begin
                            ticks_left = ticks_left - 8'd1;
                        end
                    end
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        function void compare(string field, logic [7:0] e, logic [7:0] g);
            if (g !== e) begin
                $display("%0t %s: expected %0h, got %0h", $time, field, e, g);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("bus_command", want.bus_command, got.bus_command);
            compare("command_byte", want.command_byte, got.command_byte);
            compare("want_data", want.want_data, got.want_data);
            compare("read_valid", want.read_valid, got.read_valid);
            compare("read_byte", want.read_byte, got.read_byte);
            compare("finished", want.finished, got.finished);
            compare("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_mode = '0;
    logic [7:0]  i_dev_address = '0;
    logic [15:0] i_reg_address = '0;
    logic [1:0]  i_address_length = '0;
    logic [7:0]  i_byte_count = '0;
    logic [7:0]  i_tx_byte = '0;
    logic [7:0]  i_bus_status = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_bus_command;
    logic [7:0]  o_command_byte;
    logic        o_want_data;
    logic        o_read_valid;
    logic [7:0]  o_read_byte;
    logic        o_finished;
    logic [2:0]  o_error_code;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    sequencer_scoreboard sb;
    t_request    pending_events[$];
    int          formed_count = 0;
    logic [7:0]  timeout_now = TIMEOUT_RESET;
    int          send_idle_pct = 16;
    int          recv_idle_pct = 68;
    int          set_no = 0;
    int unsigned cycles = 0;

    logic [7:0] set_timeout[NUM_SETS] = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd3, TIMEOUT_RESET};
    int send_idle_tbl[NUM_SETS] = '{16, 16, 68, 68, 0, 0};
    int recv_idle_tbl[NUM_SETS] = '{68, 68, 16, 16, 0, 0};

    i2c_master_transaction_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_dev_address   (i_dev_address),
        .i_reg_address   (i_reg_address),
        .i_address_length(i_address_length),
        .i_byte_count    (i_byte_count),
        .i_tx_byte       (i_tx_byte),
        .i_bus_status    (i_bus_status),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bus_command   (o_bus_command),
        .o_command_byte  (o_command_byte),
        .o_want_data     (o_want_data),
        .o_read_valid    (o_read_valid),
        .o_read_byte     (o_read_byte),
        .o_finished      (o_finished),
        .o_error_code    (o_error_code),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_request random_event(logic [2:0] mode);
        t_request it;
        it.mode = mode;
        it.dev_address = 8'($urandom);
        it.reg_address = 16'($urandom);
        it.address_length = 2'($urandom);
        it.byte_count = 8'($urandom);
        it.tx_byte = 8'($urandom);
        it.bus_status = 8'($urandom);
        it.rx_byte = 8'($urandom);
        return it;
    endfunction

    function automatic t_request done_event(logic [7:0] status);
        t_request it;
        it = random_event(MODE_DONE);
        it.bus_status = status;
        return it;
    endfunction

    function automatic void queue_event(t_request it, bit formed);
        pending_events.push_back(it);
        if (formed)
            formed_count++;
    endfunction

    function automatic bit status_ok(t_step kind, logic [7:0] status);
        logic [7:0] m;
        m = status & ST_MASK;
        case (kind)
            WANT_START:   return m == STAT_START || m == STAT_RESTART;
            WANT_SLA_W:   return m == STAT_WR_ADDR_ACK;
            WANT_MT_DATA: return m == STAT_WR_DATA_ACK;
            WANT_SLA_R:   return m == STAT_RD_ADDR_ACK;
            default:      return m == STAT_RD_DATA_ACK || m == STAT_RD_DATA_NACK;
        endcase
    endfunction

    function automatic logic [7:0] good_status(t_step kind);
        logic [7:0] pick;
        case (kind)
            WANT_START:   pick = $urandom_range(1) ? STAT_START : STAT_RESTART;
            WANT_SLA_W:   pick = STAT_WR_ADDR_ACK;
            WANT_MT_DATA: pick = STAT_WR_DATA_ACK;
            WANT_SLA_R:   pick = STAT_RD_ADDR_ACK;
            default:      pick = $urandom_range(1) ? STAT_RD_DATA_ACK : STAT_RD_DATA_NACK;
        endcase
        return pick | (~ST_MASK & 8'($urandom));
    endfunction

    // events the block must ignore at the given point of a transaction
    function automatic t_request stray_item(t_spot where);
        logic [2:0] spare;
        logic [2:0] begin_mode;
        int pick;
        spare = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        begin_mode = $urandom_range(1) ? MODE_BEGIN_RD : MODE_BEGIN_WR;
        pick = $urandom_range(3);
        case (where)
            AT_IDLE: return random_event(pick == 0 ? MODE_WR_BYTE : pick == 1 ? MODE_DONE :
                                         pick == 2 ? MODE_TICK : spare);
            AT_NEED: return random_event(pick == 0 ? MODE_TICK : pick == 1 ? MODE_DONE :
                                         pick == 2 ? begin_mode : spare);
            default: return random_event(pick == 0 ? MODE_BEGIN_WR : pick == 1 ? MODE_BEGIN_RD :
                                         pick == 2 ? MODE_WR_BYTE : spare);
        endcase
    endfunction

    // one engine completion, sometimes with a bad status or a timeout instead
    function automatic bit engine_step(t_step kind);
        t_request it;
        int ticks_to_fail;
        int roll;
        ticks_to_fail = (timeout_now == 8'd0) ? 1 : int'(timeout_now);
        if ($urandom_range(11) == 0)
            queue_event(stray_item(AT_BUSY), 1'b0);
        roll = $urandom_range(99);
        if (roll < 2) begin
            repeat (ticks_to_fail) queue_event(random_event(MODE_TICK), 1'b1);
            if ($urandom_range(1) == 0)
                queue_event(random_event(MODE_DONE), 1'b0);
            return 1'b0;
        end
        repeat ($urandom_range((ticks_to_fail > 3) ? 3 : ticks_to_fail - 1))
            queue_event(random_event(MODE_TICK), 1'b1);
        it = random_event(MODE_DONE);
        if (roll < 6) begin
            while (status_ok(kind, it.bus_status)) it.bus_status = 8'($urandom);
        end else begin
            it.bus_status = good_status(kind);
        end
        queue_event(it, 1'b1);
        return roll >= 6;
    endfunction

    function automatic void gen_transaction();
        t_request it;
        bit rd;
        int addr_bytes;
        int reads;
        rd = 1'($urandom_range(1));
        it = random_event(rd ? MODE_BEGIN_RD : MODE_BEGIN_WR);
        if ($urandom_range(19) != 0)
            it.byte_count = 8'($urandom_range(4));
        queue_event(it, 1'b1);
        addr_bytes = (it.address_length == 2'd2) ? 2 : (it.address_length == 2'd0) ? 0 : 1;
        reads = (it.byte_count == 8'd0) ? 1 : int'(it.byte_count);
        if (!engine_step(WANT_START) || !engine_step(WANT_SLA_W))
            return;
        for (int i = 0; i < addr_bytes; i++)
            if (!engine_step(WANT_MT_DATA))
                return;
        if (rd) begin
            if (!engine_step(WANT_START) || !engine_step(WANT_SLA_R))
                return;
            for (int i = 0; i < reads; i++)
                if (!engine_step(WANT_MR_DATA))
                    return;
        end else begin
            for (int i = 0; i < int'(it.byte_count); i++) begin
                if ($urandom_range(7) == 0)
                    queue_event(stray_item(AT_NEED), 1'b0);
                queue_event(random_event(MODE_WR_BYTE), 1'b1);
                if (!engine_step(WANT_MT_DATA))
                    return;
            end
        end
    endfunction

    function automatic void build_directed();
        t_request it;
        // two address bytes, one data byte, at the top of every field
        it = random_event(MODE_BEGIN_WR);
        it.dev_address = 8'hFF;
        it.reg_address = 16'hFFFF;
        it.address_length = 2'd2;
        it.byte_count = 8'd1;
        queue_event(it, 1'b1);
        queue_event(done_event(STAT_START | ~ST_MASK), 1'b1);
        queue_event(random_event(MODE_BEGIN_RD), 1'b0);
        queue_event(done_event(STAT_WR_ADDR_ACK), 1'b1);
        queue_event(random_event(MODE_WR_BYTE), 1'b0);
        queue_event(done_event(STAT_WR_DATA_ACK), 1'b1);
        queue_event(done_event(STAT_WR_DATA_ACK), 1'b1);
        it = random_event(MODE_WR_BYTE);
        it.tx_byte = 8'hFF;
        queue_event(it, 1'b1);
        queue_event(done_event(STAT_WR_DATA_ACK), 1'b1);
        // zero-byte read still takes one byte, answered with nack
        it = random_event(MODE_BEGIN_RD);
        it.dev_address = 8'h00;
        it.reg_address = 16'h0000;
        it.address_length = 2'd0;
        it.byte_count = 8'd0;
        queue_event(it, 1'b1);
        queue_event(done_event(STAT_RESTART), 1'b1);
        queue_event(done_event(STAT_WR_ADDR_ACK), 1'b1);
        queue_event(done_event(STAT_START), 1'b1);
        queue_event(done_event(STAT_RD_ADDR_ACK), 1'b1);
        it = done_event(STAT_RD_DATA_NACK);
        it.rx_byte = 8'hFF;
        queue_event(it, 1'b1);
        // address length three sends only the low byte, then stop
        it = random_event(MODE_BEGIN_WR);
        it.address_length = 2'd3;
        it.byte_count = 8'd0;
        queue_event(it, 1'b1);
        queue_event(done_event(STAT_START), 1'b1);
        queue_event(done_event(STAT_WR_ADDR_ACK), 1'b1);
        queue_event(done_event(STAT_WR_DATA_ACK), 1'b1);
        // start failure, then a completion in idle and an unused mode
        queue_event(random_event(MODE_BEGIN_WR), 1'b1);
        queue_event(done_event(~ST_MASK), 1'b1);
        queue_event(random_event(MODE_DONE), 1'b0);
        queue_event(random_event(MODE_SPARE_LAST), 1'b0);
    endfunction

    function automatic void build_set(int target);
        formed_count = 0;
        while (formed_count < target) begin
            if ($urandom_range(3) == 0)
                queue_event(stray_item(AT_IDLE), 1'b0);
            gen_transaction();
        end
    endfunction

    task automatic drive_events();
        t_request it;
        while (pending_events.size() != 0) begin
            it = pending_events.pop_front();
            i_valid <= 1'b1;
            i_mode <= it.mode;
            i_dev_address <= it.dev_address;
            i_reg_address <= it.reg_address;
            i_address_length <= it.address_length;
            i_byte_count <= it.byte_count;
            i_tx_byte <= it.tx_byte;
            i_bus_status <= it.bus_status;
            i_rx_byte <= it.rx_byte;
            do @(posedge i_clk); while (!o_ready);
            if ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic write_timeout(logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.timeout_ticks = value;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_event(t_request'{mode: i_mode, dev_address: i_dev_address,
                                         reg_address: i_reg_address,
                                         address_length: i_address_length,
                                         byte_count: i_byte_count, tx_byte: i_tx_byte,
                                         bus_status: i_bus_status, rx_byte: i_rx_byte});
            if (o_valid && i_ready)
                sb.check_result(t_result'{bus_command: o_bus_command,
                                          command_byte: o_command_byte,
                                          want_data: o_want_data, read_valid: o_read_valid,
                                          read_byte: o_read_byte, finished: o_finished,
                                          error_code: o_error_code});
        end
    end

    // receiver, with a long hold-off at the start of each set
    initial begin
        int seen_set;
        int hold_left;
        seen_set = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (set_no != seen_set) begin
                seen_set = set_no;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("i2c_master_transaction_sequencer: mismatch");
        $finish;
    end

    initial begin
        logic [7:0] tmo;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_directed();
        drive_events();
        for (int p = 0; p < NUM_SETS; p++) begin
            settle();
            tmo = (p == 3) ? 8'($urandom_range(254, 2)) : set_timeout[p];
            write_timeout(tmo);
            timeout_now = tmo;
            send_idle_pct = send_idle_tbl[p];
            recv_idle_pct = recv_idle_tbl[p];
            set_no = p + 1;
            build_set(ITEMS_PER_SET);
            drive_events();
        end
        settle();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("i2c_master_transaction_sequencer: match");
        else
            $display("i2c_master_transaction_sequencer: mismatch");
        $finish;
    end

endmodule

[i2c_master_transaction_sequencer.f]
rtl/i2cms_pkg.sv
rtl/i2c_master_transaction_sequencer.sv
test/i2c_master_transaction_sequencer_test.sv
